/* rtl/core/voltage_paced_breathing_led_top_macros.svh */
// Assertion macros shared by the voltage paced breathing LED RTL.
`ifndef VOLTAGE_PACED_BREATHING_LED_TOP_MACROS_SVH
`define VOLTAGE_PACED_BREATHING_LED_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked on clk_i, quiet while rst_ni is low.
`define VPBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, checked during reset as well.
`define VPBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define VPBL_ASSERT(lbl, prop, msg)

`define VPBL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/vpbl_pkg.sv */
// Package: widths, register indexes, reset values and series constants.
`default_nettype none

package vpbl_pkg;

  localparam int unsigned VOLT_W     = 15;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PHASE_W    = 12;
  localparam int unsigned MUL_W      = 32;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam logic [VOLT_W-1:0]   MIN_VOLT_RST   = 15'd6400;
  localparam logic [VOLT_W-1:0]   MAX_VOLT_RST   = 15'd8400;
  localparam logic [PERIOD_W-1:0] PER_AT_MIN_RST = 24'd200000;
  localparam logic [PERIOD_W-1:0] PER_AT_MAX_RST = 24'd2000000;

  localparam logic [MUL_W-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [MUL_W-1:0] ONE_Q30     = 32'd1073741824;
  localparam logic [9:0]       DUTY_SCALE  = 10'd1023;
  localparam logic [2:0]       TERM_LAST   = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VOLT   = 2'd0,
    CFG_MAX_VOLT   = 2'd1,
    CFG_PER_AT_MIN = 2'd2,
    CFG_PER_AT_MAX = 2'd3
  } cfg_reg_e;

  // Divisor of the k-th Taylor term: (2k)(2k+1).
  function automatic logic [6:0] term_div_f(input logic [2:0] k);
    logic [6:0] d;
    case (k)
      3'd1:    d = 7'd6;
      3'd2:    d = 7'd20;
      3'd3:    d = 7'd42;
      3'd4:    d = 7'd72;
      3'd5:    d = 7'd110;
      default: d = 7'd1;
    endcase
    return d;
  endfunction

  // floor(2^34 / term_div_f(k)); quotient estimate is low by at most one.
  function automatic logic [MUL_W-1:0] term_recip_f(input logic [2:0] k);
    logic [MUL_W-1:0] r;
    case (k)
      3'd1:    r = 32'd2863311530;
      3'd2:    r = 32'd858993459;
      3'd3:    r = 32'd409044504;
      3'd4:    r = 32'd238609294;
      3'd5:    r = 32'd156180628;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vpbl_if.sv */
// Valid/ready channels for LED update beats and duty beats.
`default_nettype none

interface vpbl_in_if import vpbl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 channel;
  logic [VOLT_W-1:0]    voltage_mv;
  logic [ELAPSED_W-1:0] delta_us;

  modport source (output valid, channel, voltage_mv, delta_us, input ready);
  modport sink   (input valid, channel, voltage_mv, delta_us, output ready);
endinterface

interface vpbl_out_if import vpbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              out_channel;
  logic [DUTY_W-1:0] duty;

  modport source (output valid, out_channel, duty, input ready);
  modport sink   (input valid, out_channel, duty, output ready);
endinterface

`default_nettype wire

/* rtl/core/voltage_paced_breathing_led_top.sv */
// Top level: voltage paced two channel breathing LED duty generator.
//
//  channel  | dir | handshake       | beat contents
//  ---------+-----+-----------------+----------------------------------------
//  in_i     | in  | valid / ready   | channel, voltage_mv, delta_us
//  out_o    | out | valid / ready   | out_channel, duty
//  cfg      | in  | cfg_we_i        | cfg_idx_i selects register, cfg_data_i
//
// One update beat at a time: a new beat is accepted only once the previous
// one has left the sequencer. The 24 step bit serial divider for the period
// line, the SINE_TABLE_BITS step divide for the phase and the shared 32x32
// multiplier running the six term sine series set the update time; an empty
// voltage window skips the period line.
// A stalled duty beat holds in the output register; the next update runs
// meanwhile and waits in its last step until the register frees.
// Reset loads the register defaults and clears both phase counters at once.
`default_nettype none
`include "voltage_paced_breathing_led_top_macros.svh"

module voltage_paced_breathing_led_top import vpbl_pkg::*; #(
  parameter int unsigned SineTableBits = SINE_TABLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vpbl_in_if.sink               in_i,
  vpbl_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned StepW      = $clog2(PERIOD_W + 1);
  localparam int unsigned PhaseShift = PHASE_W - SineTableBits;
  localparam int unsigned ProdW      = PERIOD_W + VOLT_W;

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_PER   = 18'b000000000000000010,
    S_MUL   = 18'b000000000000000100,
    S_DLD   = 18'b000000000000001000,
    S_DIV   = 18'b000000000000010000,
    S_PEND  = 18'b000000000000100000,
    S_CNT   = 18'b000000000001000000,
    S_WRAP  = 18'b000000000010000000,
    S_PHASE = 18'b000000000100000000,
    S_SIN0  = 18'b000000001000000000,
    S_SIN1  = 18'b000000010000000000,
    S_SIN2  = 18'b000000100000000000,
    S_TM    = 18'b000001000000000000,
    S_REC   = 18'b000010000000000000,
    S_QC    = 18'b000100000000000000,
    S_COR   = 18'b001000000000000000,
    S_DUTY  = 18'b010000000000000000,
    S_OUT   = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [VOLT_W-1:0]   min_volt_q, max_volt_q;
  logic [PERIOD_W-1:0] per_min_q, per_max_q;

  // Per channel phase counters.
  logic [PERIOD_W-1:0] ctr_q [2];

  // Captured update beat.
  logic                 ch_q;
  logic [VOLT_W-1:0]    volt_q;
  logic [ELAPSED_W-1:0] el_q;

  // Period line.
  logic [VOLT_W-1:0]   num_q, den_q;
  logic                fall_q;
  logic [PERIOD_W-1:0] pdiff_q, period_q, cnt_q;

  // Bit serial divider.
  logic [PERIOD_W-1:0] rem_q, low_q, dvs_q, quo_q;
  logic [StepW-1:0]    step_q;
  logic                div_phase_q;

  // Shared multiplier.
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_d, mul_q;

  // Sine series.
  logic [1:0]        quad_q;
  logic [10:0]       x_q;
  logic [MUL_W-1:0]  term_q, t2_q, tp_q;
  logic [MUL_W-3:0]  q0_q;
  logic [2:0]        k_q;
  logic signed [33:0] sum_q;

  // Output register.
  logic              out_valid_q;
  logic              out_ch_q;
  logic [DUTY_W-1:0] out_duty_q;

  // Combinational helpers.
  logic [VOLT_W-1:0]     volt_clamp;
  logic                  win_empty;
  logic [ProdW-1:0]      dvd;
  logic [PERIOD_W:0]     div_trial;
  logic                  div_ge;
  logic [PERIOD_W-1:0]   div_rem;
  logic [PERIOD_W-1:0]   per_line;
  logic [PERIOD_W:0]     ctr_sum;
  logic [PERIOD_W-1:0]   cnt_wrap;
  logic [PHASE_W-1:0]    phase;
  logic [6:0]            cor_div;
  logic [MUL_W-1:0]      cor_rem;
  logic [MUL_W-3:0]      term_new;
  logic [30:0]           sine_clamp;
  logic [MUL_W-1:0]      duty_arg;
  logic [41:0]           duty_sum;
  logic                  out_load;
  logic                  in_fire;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.duty        = out_duty_q;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Clamp into the window and decide whether the window is empty.
  assign win_empty  = (max_volt_q <= min_volt_q);
  always_comb begin
    volt_clamp = volt_q;
    if (volt_q < min_volt_q) volt_clamp = min_volt_q;
    if (volt_q > max_volt_q) volt_clamp = max_volt_q;
  end

  // Dividend for the period line; a falling line rounds the step up.
  assign dvd = mul_q[ProdW-1:0] +
               (fall_q ? ProdW'(den_q - VOLT_W'(1)) : ProdW'(0));

  // One restoring division step.
  assign div_trial = {rem_q, low_q[PERIOD_W-1]};
  assign div_ge    = (div_trial >= {1'b0, dvs_q});
  assign div_rem   = div_ge ? PERIOD_W'(div_trial - {1'b0, dvs_q})
                            : div_trial[PERIOD_W-1:0];

  assign per_line = fall_q ? (per_min_q - quo_q) : (per_min_q + quo_q);

  assign ctr_sum  = {1'b0, ctr_q[ch_q]} + (PERIOD_W + 1)'(el_q);
  assign cnt_wrap = (cnt_q >= period_q) ? '0 : cnt_q;

  assign phase = PHASE_W'(quo_q[SineTableBits-1:0]) << PhaseShift;

  // Exact divide of a term by (2k)(2k+1): estimate plus one correction.
  assign cor_div  = term_div_f(k_q);
  assign cor_rem  = tp_q - mul_q[MUL_W-1:0];
  assign term_new = q0_q + ((cor_rem >= MUL_W'(cor_div)) ? (MUL_W-2)'(1) : (MUL_W-2)'(0));

  always_comb begin
    if (sum_q[33]) begin
      sine_clamp = '0;
    end else if (sum_q > 34'sd1073741824) begin
      sine_clamp = 31'(ONE_Q30);
    end else begin
      sine_clamp = sum_q[30:0];
    end
  end
  assign duty_arg = quad_q[1] ? (ONE_Q30 - MUL_W'(sine_clamp))
                              : (ONE_Q30 + MUL_W'(sine_clamp));
  assign duty_sum = mul_q[41:0] + 42'(ONE_Q30);

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL: begin
        mul_a = MUL_W'(pdiff_q);
        mul_b = MUL_W'(num_q);
      end
      S_SIN0: begin
        mul_a = MUL_W'(x_q);
        mul_b = HALF_PI_Q30;
      end
      S_SIN1: begin
        mul_a = mul_q[41:10];
        mul_b = mul_q[41:10];
      end
      S_SIN2: begin
        mul_a = term_q;
        mul_b = mul_q[61:30];
      end
      S_TM: begin
        mul_a = term_q;
        mul_b = t2_q;
      end
      S_REC: begin
        mul_a = mul_q[61:30];
        mul_b = term_recip_f(k_q);
      end
      S_QC: begin
        mul_a = MUL_W'(mul_q[63:34]);
        mul_b = MUL_W'(cor_div);
      end
      S_DUTY: begin
        mul_a = duty_arg;
        mul_b = MUL_W'(DUTY_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_d = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_PER;
      S_PER:   state_d = win_empty ? S_CNT : S_MUL;
      S_MUL:   state_d = S_DLD;
      S_DLD:   state_d = S_DIV;
      S_DIV: begin
        if (step_q == StepW'(1)) state_d = div_phase_q ? S_PHASE : S_PEND;
      end
      S_PEND:  state_d = S_CNT;
      S_CNT:   state_d = S_WRAP;
      S_WRAP:  state_d = S_DIV;
      S_PHASE: state_d = S_SIN0;
      S_SIN0:  state_d = S_SIN1;
      S_SIN1:  state_d = S_SIN2;
      S_SIN2:  state_d = S_REC;
      S_TM:    state_d = S_REC;
      S_REC:   state_d = S_QC;
      S_QC:    state_d = S_COR;
      S_COR:   state_d = (k_q == TERM_LAST) ? S_DUTY : S_TM;
      S_DUTY:  state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_volt_q <= MIN_VOLT_RST;
      max_volt_q <= MAX_VOLT_RST;
      per_min_q  <= PER_AT_MIN_RST;
      per_max_q  <= PER_AT_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_VOLT:   min_volt_q <= cfg_data_i[VOLT_W-1:0];
        CFG_MAX_VOLT:   max_volt_q <= cfg_data_i[VOLT_W-1:0];
        CFG_PER_AT_MIN: per_min_q  <= cfg_data_i;
        CFG_PER_AT_MAX: per_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Phase counters: written once per update, after the wrap compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
    end else if (state_q == S_WRAP) begin
      ctr_q[ch_q] <= cnt_wrap;
    end
  end

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      div_phase_q <= 1'b0;
      k_q         <= '0;
    end else begin
      case (state_q)
        S_DLD: begin
          step_q      <= StepW'(PERIOD_W);
          div_phase_q <= 1'b0;
        end
        S_WRAP: begin
          step_q      <= StepW'(SineTableBits);
          div_phase_q <= 1'b1;
        end
        S_DIV:  step_q <= step_q - StepW'(1);
        S_SIN1: k_q <= 3'd1;
        S_COR:  k_q <= k_q + 3'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    // Hold the duty product while the result waits for the output register.
    if (state_q != S_OUT) begin
      mul_q <= mul_d;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ch_q   <= in_i.channel;
          volt_q <= in_i.voltage_mv;
          el_q   <= in_i.delta_us;
        end
      end
      S_PER: begin
        // Empty window: hold the period at minimum, skip the line.
        period_q <= (per_min_q == '0) ? PERIOD_W'(1) : per_min_q;
        num_q    <= volt_clamp - min_volt_q;
        den_q    <= max_volt_q - min_volt_q;
        fall_q   <= (per_max_q < per_min_q);
        pdiff_q  <= (per_max_q < per_min_q) ? (per_min_q - per_max_q)
                                            : (per_max_q - per_min_q);
      end
      S_DLD: begin
        // High part is already below the divisor: 24 quotient bits suffice.
        rem_q <= PERIOD_W'(dvd[ProdW-1:PERIOD_W]);
        low_q <= dvd[PERIOD_W-1:0];
        dvs_q <= PERIOD_W'(den_q);
      end
      S_DIV: begin
        rem_q <= div_rem;
        low_q <= {low_q[PERIOD_W-2:0], 1'b0};
        quo_q <= {quo_q[PERIOD_W-2:0], div_ge};
      end
      S_PEND: begin
        period_q <= (per_line == '0) ? PERIOD_W'(1) : per_line;
      end
      S_CNT: begin
        // Saturate before the wrap compare.
        cnt_q <= ctr_sum[PERIOD_W] ? {PERIOD_W{1'b1}} : ctr_sum[PERIOD_W-1:0];
      end
      S_WRAP: begin
        // Counter is below the period, so only the fraction bits remain.
        rem_q <= cnt_wrap;
        low_q <= '0;
        dvs_q <= period_q;
      end
      S_PHASE: begin
        quad_q <= phase[PHASE_W-1:PHASE_W-2];
        x_q    <= phase[PHASE_W-2] ? (11'd1024 - {1'b0, phase[9:0]})
                                   : {1'b0, phase[9:0]};
      end
      S_SIN1: begin
        term_q <= mul_q[41:10];
        sum_q  <= $signed({2'b00, mul_q[41:10]});
      end
      S_SIN2: t2_q <= mul_q[61:30];
      S_REC:  tp_q <= mul_q[61:30];
      S_QC:   q0_q <= mul_q[63:34];
      S_COR: begin
        term_q <= MUL_W'(term_new);
        if (k_q[0]) begin
          sum_q <= sum_q - $signed({4'b0000, term_new});
        end else begin
          sum_q <= sum_q + $signed({4'b0000, term_new});
        end
      end
      default: ;
    endcase
  end

  // Output register: load when free or drained this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_duty_q <= duty_sum[40:31];
    end
  end

  `VPBL_ASSERT(a_busy_after_accept, in_fire |=> !in_i.ready, "update accepted but block stayed ready")
  `VPBL_ASSERT(a_div_rem_below, (state_q == S_DIV) |-> (rem_q < dvs_q), "divider remainder reached divisor")
  `VPBL_ASSERT(a_ctr_below_period, (state_q == S_WRAP) |=> (ctr_q[ch_q] < period_q), "phase counter not below period")
  `VPBL_ASSERT(a_term_one_fix, (state_q == S_COR) |-> ((mul_q[MUL_W-1:0] <= tp_q) && (cor_rem < (MUL_W'(cor_div) << 1))), "term estimate off by more than one")

endmodule

`default_nettype wire
